// File: src/mmsc_pkg.sv
// Shared types, character codes and the byte classifier for the Markdown marker scanner.
// Used by the top level, front, queue and back modules and by the testbench; depends on nothing.
`default_nettype none

package mmsc_pkg;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Lookahead window depth and the queue between front and back.
  localparam int WIN_DEPTH   = 4;
  localparam int QDEPTH      = 4;
  localparam int POS_FIELD_W = 16;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_H1   = 2'd1;
  localparam logic [1:0] LVL_H2   = 2'd2;
  localparam logic [1:0] LVL_H3   = 2'd3;

  typedef struct packed {
    logic star;
    logic tilde;
    logic hash;
    logic space;
    logic nl;
    logic delim;
  } mmsc_class_t;

  typedef struct packed {
    mmsc_class_t cls;
    logic        last;
  } mmsc_entry_t;

  // Packed so that position sits in the lowest bits.
  typedef struct packed {
    logic [1:0]             heading_close_level;
    logic [1:0]             heading_open_level;
    logic                   italic_close;
    logic                   italic_open;
    logic                   strike_close;
    logic                   strike_open;
    logic                   bold_close;
    logic                   bold_open;
    logic [POS_FIELD_W-1:0] position;
  } mmsc_result_t;

  function automatic mmsc_class_t mmsc_classify(input logic [7:0] c);
    mmsc_class_t k;
    k.star  = (c == CH_STAR);
    k.tilde = (c == CH_TILDE);
    k.hash  = (c == CH_HASH);
    k.space = (c == CH_SPACE);
    k.nl    = (c == CH_NL);
    // Space, newline and the four ASCII punctuation ranges.
    k.delim = (c == CH_SPACE) || (c == CH_NL) ||
              (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
              (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    return k;
  endfunction

endpackage

`default_nettype wire

// File: src/markdown_marker_scanner.sv
// Markdown marker scanner: one text byte per beat in, one marker result per position out.
// Path: the result for a byte is built once the third byte behind it (or the final byte) has
// reached the window; it passes the front register, queue, window register and output register.
// Throughput: one byte per cycle while the output is not stalled; the final byte of a text drains
// up to four results, one per cycle from the back window, and the back takes no byte of the next text until then.
// Reset: rst_n synchronous active low; clears handshakes, queue, window fill and text state.
`default_nettype none

module markdown_marker_scanner #(
  parameter int POSITION_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] char_in
  input  wire         in_tlast,   // last_char
  output logic        out_tvalid,
  input  wire         out_tready,
  // [15:0] position, [16] bold_open, [17] bold_close, [18] strike_open, [19] strike_close,
  // [20] italic_open, [21] italic_close, [23:22] heading_open_level,
  // [25:24] heading_close_level, [31:26] zero
  output logic [31:0] out_tdata,
  output logic        out_tlast   // end_of_text
);
  import mmsc_pkg::*;

  logic         f_valid, f_ready, b_valid, b_ready;
  mmsc_entry_t  f_entry, b_entry;
  mmsc_result_t result;

  mmsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_entry   (f_entry)
  );

  mmsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_entry (f_entry),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_entry  (b_entry)
  );

  mmsc_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_entry    (b_entry),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (result),
    .out_eot    (out_tlast)
  );

  assign out_tdata = {{(32 - $bits(mmsc_result_t)){1'b0}}, result};

endmodule

`default_nettype wire

// File: src/mmsc_front.sv
// Input stage: accepts text bytes, classifies each one and registers it for the queue.
// Depends on mmsc_pkg.
`default_nettype none

module mmsc_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [7:0]           in_tdata,   // [7:0] char_in
  input  wire                  in_tlast,   // last_char
  output logic                 q_valid,
  input  wire                  q_ready,
  output mmsc_pkg::mmsc_entry_t q_entry
);
  import mmsc_pkg::*;

  logic        valid_r, valid_nxt;
  mmsc_entry_t entry_r, entry_nxt;

  assign in_tready = !valid_r || q_ready;
  assign q_valid   = valid_r;
  assign q_entry   = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
      entry_nxt.cls  = mmsc_classify(in_tdata);
      entry_nxt.last = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// File: src/mmsc_queue.sv
// Short register queue of classified bytes between the front and back parts.
// Depends on mmsc_pkg.
`default_nettype none

module mmsc_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push_valid,
  output logic                  push_ready,
  input  wire  mmsc_pkg::mmsc_entry_t push_entry,
  output logic                  pop_valid,
  input  wire                   pop_ready,
  output mmsc_pkg::mmsc_entry_t pop_entry
);
  import mmsc_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  mmsc_entry_t    entries_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != QDEPTH[QAW:0]);
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{QAW{1'b0}}, do_push} - {{QAW{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// File: src/mmsc_back.sv
// Back part: four-byte lookahead window, marker detectors, position and heading state,
// and the output register. Depends on mmsc_pkg.
`default_nettype none

module mmsc_back #(
  parameter int POSITION_WIDTH = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  output logic                  q_ready,
  input  wire  mmsc_pkg::mmsc_entry_t q_entry,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output mmsc_pkg::mmsc_result_t out_result,
  output logic                  out_eot
);
  import mmsc_pkg::*;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

  mmsc_class_t win_r [WIN_DEPTH];
  mmsc_class_t win_nxt [WIN_DEPTH];
  logic [2:0]  fill_r, fill_nxt, fill_s;
  logic        flush_r, flush_nxt;
  logic        ws_r, ws_nxt;   // byte before the front is a space or newline
  logic        ls_r, ls_nxt;   // byte before the front is a newline
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [1:0]  lvl_r, lvl_nxt;
  logic        out_valid_r, out_valid_nxt;
  mmsc_result_t res_r, res_nxt;
  logic        eot_r, eot_nxt;

  logic        can_load, emit, pop;
  logic        v1, v2, v3, n_is1, n_is2, two_star, two_tilde;
  logic        end0, end1;
  logic [1:0]  open_lvl;
  logic [POS_FIELD_W-1:0] pos_cap;

  generate
    if (POSITION_WIDTH > POS_FIELD_W) begin : g_cap
      assign pos_cap = (|pos_r[POSITION_WIDTH-1:POS_FIELD_W]) ? {POS_FIELD_W{1'b1}}
                                                              : pos_r[POS_FIELD_W-1:0];
    end else if (POSITION_WIDTH == POS_FIELD_W) begin : g_eq
      assign pos_cap = pos_r;
    end else begin : g_ext
      assign pos_cap = {{(POS_FIELD_W-POSITION_WIDTH){1'b0}}, pos_r};
    end
  endgenerate

  assign can_load   = !out_valid_r || out_tready;
  // A full window reports its front; after the final byte the rest drains one per cycle unless the output stalls.
  assign emit       = can_load && ((fill_r == 3'd4) || (flush_r && fill_r != 3'd0));
  assign pop        = q_valid && !flush_r && ((fill_r != 3'd4) || emit);
  assign q_ready    = !flush_r && ((fill_r != 3'd4) || emit);
  assign out_tvalid = out_valid_r;
  assign out_result = res_r;
  assign out_eot    = eot_r;

  always_comb begin
    v1    = (fill_r > 3'd1);
    v2    = (fill_r > 3'd2);
    v3    = (fill_r > 3'd3);
    n_is1 = (fill_r == 3'd1);
    n_is2 = (fill_r == 3'd2);
    two_star  = v1 && win_r[0].star && win_r[1].star;
    two_tilde = v1 && win_r[0].tilde && win_r[1].tilde;
    end0 = (flush_r && n_is1) || (v1 && win_r[1].delim);
    end1 = (flush_r && n_is2) || (v2 && win_r[2].delim);

    open_lvl = LVL_NONE;
    if (ls_r && win_r[0].hash) begin
      priority if (v1 && win_r[1].space) begin
        open_lvl = LVL_H1;
      end else if (v2 && win_r[1].hash && win_r[2].space) begin
        open_lvl = LVL_H2;
      end else if (v3 && win_r[1].hash && win_r[2].hash && win_r[3].space) begin
        open_lvl = LVL_H3;
      end else begin
        open_lvl = LVL_NONE;
      end
    end

    res_nxt.position            = pos_cap;
    res_nxt.bold_open           = two_star && ws_r;
    res_nxt.bold_close          = two_star && end1;
    res_nxt.strike_open         = two_tilde && ws_r;
    res_nxt.strike_close        = two_tilde && end1;
    res_nxt.italic_open         = win_r[0].star && ws_r;
    res_nxt.italic_close        = win_r[0].star && end0;
    res_nxt.heading_open_level  = open_lvl;
    res_nxt.heading_close_level = win_r[0].nl ? lvl_r : LVL_NONE;
    eot_nxt                     = flush_r && n_is1;
    if (!emit) begin
      res_nxt = res_r;
      eot_nxt = eot_r;
    end
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_tready);

    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (emit) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[WIN_DEPTH-1] = '0;
    end
    fill_s    = fill_r - {2'b00, emit};
    fill_nxt  = fill_s;
    flush_nxt = flush_r;
    if (pop) begin
      win_nxt[fill_s[1:0]] = q_entry.cls;
      fill_nxt  = fill_s + 3'd1;
      flush_nxt = q_entry.last;
    end

    ws_nxt  = ws_r;
    ls_nxt  = ls_r;
    pos_nxt = pos_r;
    lvl_nxt = lvl_r;
    if (emit && flush_r && n_is1) begin
      // Text done: back to the state of a fresh text.
      fill_nxt  = 3'd0;
      flush_nxt = 1'b0;
      ws_nxt    = 1'b1;
      ls_nxt    = 1'b1;
      pos_nxt   = '0;
      lvl_nxt   = LVL_NONE;
    end else if (emit) begin
      ws_nxt  = win_r[0].space || win_r[0].nl;
      ls_nxt  = win_r[0].nl;
      pos_nxt = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
      if (open_lvl != LVL_NONE) begin
        lvl_nxt = open_lvl;
      end
      if (win_r[0].nl) begin
        lvl_nxt = LVL_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 3'd0;
      flush_r     <= 1'b0;
      ws_r        <= 1'b1;
      ls_r        <= 1'b1;
      pos_r       <= '0;
      lvl_r       <= LVL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      flush_r     <= flush_nxt;
      ws_r        <= ws_nxt;
      ls_r        <= ls_nxt;
      pos_r       <= pos_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_r[i] <= win_nxt[i];
    end
    res_r <= res_nxt;
    eot_r <= eot_nxt;
  end

endmodule

`default_nettype wire

// File: src/mmsc_checker.sv
// Port-level checks for the Markdown marker scanner, bound to the top level.
// Depends on markdown_marker_scanner's port list only.
`default_nettype none

module mmsc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tlast
);

  // A stalled result beat keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A bold opener is a star at word start, so the italic opener fires with it.
  a_bold_italic: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[20])
    else $error("bold opener without italic opener");

  // Tilde and star markers cannot share a position.
  a_strike_star: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[18] || out_tdata[19]) |-> out_tdata[21:20] == 2'b00 &&
    out_tdata[17:16] == 2'b00)
    else $error("strike and star markers at one position");

  // A heading opener sits on a hash, a closer on a newline.
  a_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:22] != 2'b00 |-> out_tdata[25:24] == 2'b00)
    else $error("heading opened and closed at one position");

endmodule

bind markdown_marker_scanner mmsc_checker u_mmsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// File: tb/sv/markdown_marker_scanner_tb.sv
// Self-checking testbench for the Markdown marker scanner: streams texts into the byte channel,
// predicts every per-position marker result and compares each result beat field by field.
// Depends on mmsc_pkg and markdown_marker_scanner.
`default_nettype none

module markdown_marker_scanner_tb;
  import mmsc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_TEXT    = 40;
  localparam int RANDOM_BYTES = 340;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  typedef struct {
    logic [31:0] data;
    logic        last;
  } marker_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  markdown_marker_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  int cyc = 0;
  always @(posedge clk) cyc <= cyc + 1;

  text_beat_t   text_q [$];
  marker_beat_t marker_q [$];
  text_beat_t   drv_beat;
  int mismatches = 0;
  int texts_sent = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int marked_results = 0;

  // Scanner state as the predictor sees it.
  logic [7:0]  win [4];
  int          fill;
  logic [7:0]  prev_ch;
  logic [15:0] next_pos;
  logic [1:0]  line_lvl;

  task automatic clear_scan();
    for (int i = 0; i < 4; i++) win[i] = 8'h00;
    fill     = 0;
    prev_ch  = CH_NL;
    next_pos = '0;
    line_lvl = LVL_NONE;
  endtask

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c >= 8'h21 && c <= 8'h2F) ||
           (c >= 8'h3A && c <= 8'h40) || (c >= 8'h5B && c <= 8'h60) ||
           (c >= 8'h7B && c <= 8'h7E);
  endfunction

  // True when the byte at window slot k is followed by a delimiter or closes the text.
  function automatic logic ends_word(input int k, input int n, input logic fin);
    if (fin && k + 1 == n) return 1'b1;
    if (k + 1 < n && k + 1 < 4) return is_delim(win[k + 1]);
    return 1'b0;
  endfunction

  task automatic report_oldest(input int n, input logic fin);
    logic [7:0]   c0, c1, c2, c3;
    logic         word_start, line_start, two_star, two_tilde;
    logic [1:0]   lvl_open, lvl_close;
    mmsc_result_t r;
    marker_beat_t b;
    c0 = win[0];
    c1 = (n > 1) ? win[1] : 8'h00;
    c2 = (n > 2) ? win[2] : 8'h00;
    c3 = (n > 3) ? win[3] : 8'h00;
    word_start = (prev_ch == CH_SPACE) || (prev_ch == CH_NL);
    line_start = (prev_ch == CH_NL);
    two_star   = (n > 1) && c0 == CH_STAR && c1 == CH_STAR;
    two_tilde  = (n > 1) && c0 == CH_TILDE && c1 == CH_TILDE;
    lvl_open   = LVL_NONE;
    lvl_close  = LVL_NONE;
    if (line_start && c0 == CH_HASH) begin
      if (n > 1 && c1 == CH_SPACE) lvl_open = LVL_H1;
      else if (n > 2 && c1 == CH_HASH && c2 == CH_SPACE) lvl_open = LVL_H2;
      else if (n > 3 && c1 == CH_HASH && c2 == CH_HASH && c3 == CH_SPACE) lvl_open = LVL_H3;
    end
    if (lvl_open != LVL_NONE) line_lvl = lvl_open;
    if (c0 == CH_NL) begin
      lvl_close = line_lvl;
      line_lvl  = LVL_NONE;
    end
    r.position            = next_pos;
    r.bold_open           = two_star && word_start;
    r.bold_close          = two_star && ends_word(1, n, fin);
    r.strike_open         = two_tilde && word_start;
    r.strike_close        = two_tilde && ends_word(1, n, fin);
    r.italic_open         = (c0 == CH_STAR) && word_start;
    r.italic_close        = (c0 == CH_STAR) && ends_word(0, n, fin);
    r.heading_open_level  = lvl_open;
    r.heading_close_level = lvl_close;
    b.data = {6'b0, r};
    b.last = fin && n == 1;
    marker_q.push_back(b);
    if (r[25:16] != '0) marked_results++;
    if (next_pos != POS_MAX) next_pos++;
    prev_ch = c0;
    for (int i = 0; i < 3; i++) win[i] = win[i + 1];
    win[3] = 8'h00;
    if (fill > 0) fill--;
  endtask

  task automatic scan_byte(input logic [7:0] ch, input logic last);
    int cnt;
    cnt = 0;
    if (fill > 3) fill = 3;
    win[fill] = ch;
    fill++;
    if (last) begin
      while (fill > 0 && cnt < 4) begin
        report_oldest(fill, 1'b1);
        cnt++;
      end
      clear_scan();
    end else if (fill == 4) begin
      report_oldest(4, 1'b0);
    end
  endtask

  // Random gaps, with two windows of full-rate traffic.
  function automatic logic take_break();
    if (cyc >= 300 && cyc < 900) return 1'b0;
    if (cyc >= 40_000 && cyc < 60_000) return 1'b0;
    return $urandom_range(99) < 16;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cyc, what);
  endtask

  task automatic check_field(input string name, input int got, input int want, input int pos);
    if (got != want)
      note_mismatch($sformatf("%s got %0h expected %0h at position %0d", name, got, want, pos));
  endtask

  task automatic check_result();
    marker_beat_t b;
    mmsc_result_t got, want;
    if (marker_q.size() == 0) begin
      note_mismatch($sformatf("unexpected result beat %h", out_tdata));
      return;
    end
    b    = marker_q.pop_front();
    got  = out_tdata[25:0];
    want = b.data[25:0];
    results_checked++;
    check_field("position", got.position, want.position, want.position);
    check_field("bold_open", got.bold_open, want.bold_open, want.position);
    check_field("bold_close", got.bold_close, want.bold_close, want.position);
    check_field("strike_open", got.strike_open, want.strike_open, want.position);
    check_field("strike_close", got.strike_close, want.strike_close, want.position);
    check_field("italic_open", got.italic_open, want.italic_open, want.position);
    check_field("italic_close", got.italic_close, want.italic_close, want.position);
    check_field("heading_open_level", got.heading_open_level, want.heading_open_level,
                want.position);
    check_field("heading_close_level", got.heading_close_level, want.heading_close_level,
                want.position);
    check_field("padding", out_tdata[31:26], 0, want.position);
    check_field("end_of_text", out_tlast, b.last, want.position);
  endtask

  // Byte driver: the predictor runs on every accepted beat.
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      scan_byte(in_tdata, in_tlast);
      bytes_sent++;
      if (in_tlast) texts_sent++;
    end
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (text_q.size() > 0 && !take_break()) begin
        drv_beat = text_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= drv_beat.ch;
        in_tlast  <= drv_beat.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !take_break();
  end

  task automatic push_byte(input logic [7:0] ch, input logic last);
    text_beat_t t;
    t.ch   = ch;
    t.last = last;
    text_q.push_back(t);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  // Builds one text from Markdown-like tokens or random bytes, ending with the final-byte flag.
  task automatic push_random_text(output int len);
    logic [7:0] tb_buf [$];
    string      punct;
    int         n_tok, t, k;
    punct = ".,!?:;)-_[]{}@`/";
    tb_buf.delete();
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(1, 8);
      repeat (k) tb_buf.push_back(8'($urandom_range(255)));
    end else begin
      n_tok = $urandom_range(1, 6);
      repeat (n_tok) begin
        t = $urandom_range(99);
        if (t < 15) begin
          k = $urandom_range(1, 4);
          repeat (k) tb_buf.push_back(8'(8'h61 + $urandom_range(25)));
        end else if (t < 25) tb_buf.push_back(CH_SPACE);
        else if (t < 32) tb_buf.push_back(CH_NL);
        else if (t < 44) begin
          tb_buf.push_back(CH_STAR);
          tb_buf.push_back(CH_STAR);
        end else if (t < 52) begin
          tb_buf.push_back(CH_TILDE);
          tb_buf.push_back(CH_TILDE);
        end else if (t < 62) tb_buf.push_back(CH_STAR);
        else if (t < 72) begin
          if (tb_buf.size() > 0 && $urandom_range(1)) tb_buf.push_back(CH_NL);
          k = $urandom_range(1, 4);
          repeat (k) tb_buf.push_back(CH_HASH);
          if ($urandom_range(4) != 0) tb_buf.push_back(CH_SPACE);
        end else if (t < 80) tb_buf.push_back(punct[$urandom_range(punct.len() - 1)]);
        else if (t < 90) tb_buf.push_back($urandom_range(1) ? CH_TILDE : CH_HASH);
        else tb_buf.push_back(8'($urandom_range(255)));
      end
    end
    len = tb_buf.size();
    for (int i = 0; i < len; i++) push_byte(tb_buf[i], i == len - 1);
  endtask

  function automatic logic [7:0] long_text_char();
    string alpha;
    alpha = "abc *~#\n.";
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return alpha[$urandom_range(alpha.len() - 1)];
  endfunction

  initial begin
    int random_bytes, len;
    clear_scan();
    // Directed: lone star at the end, double markers cut by the end, headings of every level.
    push_text("*");
    push_text("**");
    push_text("~~");
    push_text("# a\n## b\n### c\n");
    // Extreme byte values; a star before a non-ASCII byte is no closer.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_STAR, 1'b0);
    push_byte(8'h80, 1'b1);
    push_text("a*b*.");
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      push_random_text(len);
      random_bytes += len;
    end
    // One longer text of mixed markers, then a short one after it.
    for (int i = 0; i < LONG_TEXT; i++) push_byte(long_text_char(), i == LONG_TEXT - 1);
    push_text("**x** ~~y~~");

    wait (rst_n);
    while (text_q.size() > 0 || in_tvalid || marker_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("summary: %0d texts, %0d bytes sent, %0d results checked, %0d with a marker",
             texts_sent, bytes_sent, results_checked, marked_results);
    $display("summary: includes one %0d-byte text of mixed markers and odd bytes", LONG_TEXT);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    wait (cyc >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cyc, marker_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/mmsc_pkg.sv
src/mmsc_front.sv
src/mmsc_queue.sv
src/mmsc_back.sv
src/markdown_marker_scanner.sv
src/mmsc_checker.sv
tb/sv/markdown_marker_scanner_tb.sv
